// File: hw/rtl/scl_pkg.sv
// Shared types, constants and helper functions for the serial command line parser.
// Used by scl_line_parser and serial_command_line_parser_unit; no dependencies.
`default_nettype none

package scl_pkg;

   localparam int LINE_MAX_DEF = 128;
   localparam int TARGET_W     = 32;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UB    = 8'h42;
   localparam logic [7:0] CHAR_UO    = 8'h4F;
   localparam logic [7:0] CHAR_UR    = 8'h52;
   localparam logic [7:0] CHAR_UT    = 8'h54;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LT    = 8'h74;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;

   localparam logic [2:0] ABORT_LEN = 3'd5;

   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

   localparam logic CMD_SET_TARGET = 1'b0;
   localparam logic CMD_ABORT      = 1'b1;

   typedef enum logic [8:0] {
      PH_START    = 9'b000000001,
      PH_T        = 9'b000000010,
      PH_WS       = 9'b000000100,
      PH_INT      = 9'b000001000,
      PH_FRAC     = 9'b000010000,
      PH_NUMEND   = 9'b000100000,
      PH_ABORT    = 9'b001000000,
      PH_ABORT_OK = 9'b010000000,
      PH_DONE     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic                       valid;
      logic                       command;
      logic signed [TARGET_W-1:0] target;
   } result_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CHAR_LA && c <= CHAR_LZ) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] abort_letter(input logic [2:0] idx);
      logic [7:0] letter;
      unique case (idx)
         3'd0:    letter = CHAR_UA;
         3'd1:    letter = CHAR_UB;
         3'd2:    letter = CHAR_UO;
         3'd3:    letter = CHAR_UR;
         3'd4:    letter = CHAR_UT;
         default: letter = CHAR_NUL;
      endcase
      return letter;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/serial_command_line_parser_unit.sv
// Top level of the serial command line parser: input register, line parser, result register.
// Depends on scl_pkg and scl_line_parser.
`default_nettype none

// Takes one received byte per transaction and emits a transaction with a set-target or
// abort command when a line feed closes a recognized line. One byte is accepted every
// cycle unless req_stall is raised; a result is offered from the result register once
// its line feed has been parsed out of the input register, and the input keeps flowing
// while a result waits, except when a line feed that closes another recognized line
// meets a result that is still stalled. The parser state for the line lives in
// scl_line_parser and is updated once per accepted byte. LINE_MAX sets the line length
// at which an overlong line is dropped and restarted.

module serial_command_line_parser_unit #(
   parameter int LINE_MAX = scl_pkg::LINE_MAX_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_command,
   output      logic signed [scl_pkg::TARGET_W-1:0] rsp_target_hundredths
);
   import scl_pkg::*;

   logic                       in_vld_ff, in_vld_in;
   logic [7:0]                 in_byte_ff, in_byte_in;
   logic                       out_vld_ff, out_vld_in;
   logic                       out_cmd_ff, out_cmd_in;
   logic signed [TARGET_W-1:0] out_tgt_ff, out_tgt_in;
   result_type                 result;
   logic                       out_free;
   logic                       in_adv;
   logic                       out_load;

   scl_line_parser #(
      .LINE_MAX (LINE_MAX)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_adv),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign in_adv    = in_vld_ff && (!result.valid || out_free);
   assign out_load  = in_adv && result.valid;
   assign req_stall = in_vld_ff && !in_adv;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (!req_stall) begin
         in_vld_in  = req_valid;
         in_byte_in = req_rx_byte;
      end
      out_vld_in = out_vld_ff;
      out_cmd_in = out_cmd_ff;
      out_tgt_in = out_tgt_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
         out_cmd_in = result.command;
         out_tgt_in = result.target;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_byte_ff <= in_byte_in;
      out_cmd_ff <= out_cmd_in;
      out_tgt_ff <= out_tgt_in;
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_command           = out_cmd_ff;
   assign rsp_target_hundredths = out_tgt_ff;

`ifndef SYNTH
   a_load_on_lf : assert property (@(posedge clock) disable iff (reset)
      out_load |-> in_byte_ff == CHAR_LF)
      else $error("result loaded for a byte other than line feed");

   a_abort_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_ABORT |-> rsp_target_hundredths == '0)
      else $error("abort transaction carries a nonzero target");

   a_stall_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && result.valid && out_vld_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_out_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_hundredths))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/scl_line_parser.sv
// Line state and per-byte parse logic for the serial command line parser.
// Depends on scl_pkg; the result for the current byte is combinational.
`default_nettype none

module scl_line_parser #(
   parameter int LINE_MAX = scl_pkg::LINE_MAX_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [7:0]         rx_byte,
   output scl_pkg::result_type     result
);
   import scl_pkg::*;

   localparam int CNT_W = $clog2(LINE_MAX);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_MAX - 1);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       match_ff, match_in;
   logic [31:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [1:0]       frac_ff, frac_in;
   logic             seen_ff, seen_in;

   logic        is_digit;
   logic [3:0]  digit;
   logic        do_int;
   logic        do_acc;
   logic [35:0] base;
   logic [9:0]  term;
   logic [35:0] sum;
   logic [31:0] acc_sat;
   logic        num_ph;

   assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
   assign digit    = rx_byte[3:0];

   always_comb begin
      base = do_int ? ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) : {4'd0, acc_ff};
      if (do_int) begin
         term = 10'(digit) * 10'd100;
      end else if (frac_ff == 2'd0) begin
         term = 10'(digit) * 10'd10;
      end else begin
         term = 10'(digit);
      end
      sum     = base + 36'(term);
      acc_sat = (sum > 36'(MAG_LIMIT)) ? MAG_LIMIT : sum[31:0];
   end

   assign num_ph = (phase_ff == PH_INT) || (phase_ff == PH_FRAC) || (phase_ff == PH_NUMEND);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      match_in = match_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      frac_in  = frac_ff;
      seen_in  = seen_ff;
      do_int   = 1'b0;
      do_acc   = 1'b0;
      result   = '0;

      if (rx_byte == CHAR_CR) begin
         phase_in = phase_ff;
      end else if (rx_byte == CHAR_LF || count_ff >= CNT_LIMIT) begin
         if (rx_byte == CHAR_LF) begin
            if (num_ph && seen_ff) begin
               result.valid   = 1'b1;
               result.command = CMD_SET_TARGET;
               result.target  = neg_ff ? signed'(32'd0 - acc_ff)
                                       : signed'((acc_ff > POS_MAX) ? POS_MAX : acc_ff);
            end else if (phase_ff == PH_ABORT_OK ||
                         (phase_ff == PH_ABORT &&
                          (match_ff == 3'd1 || match_ff == ABORT_LEN))) begin
               result.valid   = 1'b1;
               result.command = CMD_ABORT;
               result.target  = '0;
            end
         end
         phase_in = PH_START;
         count_in = '0;
         match_in = '0;
         acc_in   = '0;
         neg_in   = 1'b0;
         frac_in  = '0;
         seen_in  = 1'b0;
      end else begin
         count_in = count_ff + CNT_W'(1);
         if (rx_byte == CHAR_NUL && phase_ff != PH_ABORT) begin
            if (phase_ff == PH_INT || phase_ff == PH_FRAC) begin
               phase_in = PH_NUMEND;
            end else if (phase_ff != PH_NUMEND && phase_ff != PH_ABORT_OK) begin
               phase_in = PH_DONE;
            end
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (rx_byte == CHAR_SPACE || rx_byte == CHAR_TAB) begin
                     phase_in = PH_START;
                  end else if (rx_byte == CHAR_UT || rx_byte == CHAR_LT) begin
                     phase_in = PH_T;
                  end else if (rx_byte == CHAR_UA || rx_byte == CHAR_LA) begin
                     phase_in = PH_ABORT;
                     match_in = 3'd1;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_T: begin
                  phase_in = (rx_byte == CHAR_COMMA) ? PH_WS : PH_DONE;
               end
               PH_WS: begin
                  if (rx_byte == CHAR_SPACE || rx_byte == CHAR_TAB ||
                      rx_byte == CHAR_VT || rx_byte == CHAR_FF) begin
                     phase_in = PH_WS;
                  end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
                     neg_in   = (rx_byte == CHAR_MINUS);
                     phase_in = PH_INT;
                  end else if (is_digit) begin
                     phase_in = PH_INT;
                     do_int   = 1'b1;
                     do_acc   = 1'b1;
                  end else if (rx_byte == CHAR_DOT) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_INT: begin
                  if (is_digit) begin
                     do_int = 1'b1;
                     do_acc = 1'b1;
                  end else if (rx_byte == CHAR_DOT) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_NUMEND;
                  end
               end
               PH_FRAC: begin
                  if (is_digit) begin
                     seen_in = 1'b1;
                     if (frac_ff < 2'd2) begin
                        do_acc  = 1'b1;
                        frac_in = frac_ff + 2'd1;
                     end
                  end else begin
                     phase_in = PH_NUMEND;
                  end
               end
               PH_ABORT: begin
                  if (rx_byte == CHAR_NUL) begin
                     phase_in = (match_ff == 3'd1 || match_ff == ABORT_LEN) ? PH_ABORT_OK
                                                                            : PH_DONE;
                  end else if (match_ff >= ABORT_LEN) begin
                     phase_in = (rx_byte == CHAR_SPACE || rx_byte == CHAR_TAB) ? PH_ABORT_OK
                                                                               : PH_DONE;
                  end else if (to_upper(rx_byte) == abort_letter(match_ff)) begin
                     match_in = match_ff + 3'd1;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_NUMEND, PH_ABORT_OK, PH_DONE: begin
                  phase_in = phase_ff;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
         if (do_acc) begin
            acc_in  = acc_sat;
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         count_ff <= '0;
         match_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         frac_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         match_ff <= match_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         frac_ff  <= frac_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for serial_command_line_parser_unit: streams command lines byte by
// byte, predicts set-target and abort commands, and checks every result transaction.
// Depends on scl_pkg and the RTL of serial_command_line_parser_unit.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scl_pkg::*;

   localparam int LINE_LIMIT  = LINE_MAX_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam logic [4:0][7:0] ABORT_WORD = {CHAR_UT, CHAR_UR, CHAR_UO, CHAR_UB, CHAR_UA};

   typedef struct packed {
      logic                       command;
      logic signed [TARGET_W-1:0] target;
   } line_cmd_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic                       rsp_command;
   logic signed [TARGET_W-1:0] rsp_target_hundredths;

   logic [7:0]   pending_bytes[$];
   line_cmd_type expected_commands[$];

   int cycle_count = 0;
   int n_sent      = 0;
   int n_errors    = 0;
   int n_set       = 0;
   int n_abort     = 0;
   int n_long      = 0;
   int gap_left    = 0;
   int stall_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit rush        = 1'b0;
   bit quiet       = 1'b0;

   // line parser prediction state
   int          line_len;
   phase_type   line_phase;
   logic [2:0]  abort_idx;
   logic [31:0] mag_acc;
   logic        mag_negative;
   int          frac_taken;
   logic        got_digit;

   serial_command_line_parser_unit #(.LINE_MAX(LINE_LIMIT)) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_command           (rsp_command),
      .rsp_target_hundredths (rsp_target_hundredths)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      n_errors++;
   endtask

   task automatic restart_line();
      line_phase   = PH_START;
      abort_idx    = '0;
      mag_acc      = '0;
      mag_negative = 1'b0;
      frac_taken   = 0;
      got_digit    = 1'b0;
   endtask

   task automatic add_to_mag(input logic [63:0] sum);
      mag_acc   = (sum > {32'b0, MAG_LIMIT}) ? MAG_LIMIT : sum[31:0];
      got_digit = 1'b1;
   endtask

   task automatic parse_rx_byte(input logic [7:0] c);
      logic                       is_digit;
      logic                       is_blank;
      logic [7:0]                 upper;
      logic [63:0]                digit;
      line_cmd_type               cmd;
      is_digit = (c >= CHAR_0 && c <= CHAR_9);
      is_blank = (c == CHAR_SPACE || c == CHAR_TAB);
      upper    = (c >= CHAR_LA && c <= CHAR_LZ) ? c - 8'd32 : c;
      digit    = {56'b0, c - CHAR_0};
      if (c == CHAR_CR) return;
      if (c == CHAR_LF) begin
         if ((line_phase == PH_INT || line_phase == PH_FRAC || line_phase == PH_NUMEND)
             && got_digit) begin
            cmd.command = CMD_SET_TARGET;
            cmd.target  = mag_negative ? 32'(32'd0 - mag_acc)
                                       : ((mag_acc > POS_MAX) ? POS_MAX : mag_acc);
            expected_commands.push_back(cmd);
         end else if (line_phase == PH_ABORT_OK || (line_phase == PH_ABORT &&
                      (abort_idx == 3'd1 || abort_idx == ABORT_LEN))) begin
            cmd.command = CMD_ABORT;
            cmd.target  = '0;
            expected_commands.push_back(cmd);
         end
         line_len = 0;
         restart_line();
         return;
      end
      if (line_len >= LINE_LIMIT - 1) begin
         line_len = 0;
         restart_line();
         return;
      end
      line_len++;
      if (c == CHAR_NUL && line_phase != PH_ABORT) begin
         if (line_phase == PH_INT || line_phase == PH_FRAC) line_phase = PH_NUMEND;
         else if (line_phase != PH_NUMEND && line_phase != PH_ABORT_OK) line_phase = PH_DONE;
         return;
      end
      case (line_phase)
         PH_START: begin
            if (!is_blank) begin
               if (c == CHAR_UT || c == CHAR_LT) begin
                  line_phase = PH_T;
               end else if (c == CHAR_UA || c == CHAR_LA) begin
                  line_phase = PH_ABORT;
                  abort_idx  = 3'd1;
               end else begin
                  line_phase = PH_DONE;
               end
            end
         end
         PH_T: line_phase = (c == CHAR_COMMA) ? PH_WS : PH_DONE;
         PH_WS: begin
            if (!(is_blank || c == CHAR_VT || c == CHAR_FF)) begin
               if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  mag_negative = (c == CHAR_MINUS);
                  line_phase   = PH_INT;
               end else if (is_digit) begin
                  line_phase = PH_INT;
                  add_to_mag({32'b0, mag_acc} * 64'd10 + digit * 64'd100);
               end else if (c == CHAR_DOT) begin
                  line_phase = PH_FRAC;
               end else begin
                  line_phase = PH_DONE;
               end
            end
         end
         PH_INT: begin
            if (is_digit) add_to_mag({32'b0, mag_acc} * 64'd10 + digit * 64'd100);
            else if (c == CHAR_DOT) line_phase = PH_FRAC;
            else line_phase = PH_NUMEND;
         end
         PH_FRAC: begin
            if (is_digit) begin
               if (frac_taken == 0) add_to_mag({32'b0, mag_acc} + digit * 64'd10);
               else if (frac_taken == 1) add_to_mag({32'b0, mag_acc} + digit);
               else got_digit = 1'b1;
               if (frac_taken < 2) frac_taken++;
            end else begin
               line_phase = PH_NUMEND;
            end
         end
         PH_ABORT: begin
            if (c == CHAR_NUL) begin
               line_phase = (abort_idx == 3'd1 || abort_idx == ABORT_LEN) ? PH_ABORT_OK
                                                                          : PH_DONE;
            end else if (abort_idx >= ABORT_LEN) begin
               line_phase = is_blank ? PH_ABORT_OK : PH_DONE;
            end else if (upper == ABORT_WORD[abort_idx]) begin
               abort_idx++;
            end else begin
               line_phase = PH_DONE;
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   task automatic queue_random_line();
      int         kind;
      int         n;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 3 && n_long < 4) begin
         n_long++;
         n = $urandom_range(124, 130);
         repeat (n) begin
            do b = any_byte(); while (b == CHAR_LF || b == CHAR_CR);
            pending_bytes.push_back(b);
         end
         push_text("T,5");
      end else if (kind < 55) begin
         repeat ($urandom_range(0, 2)) pending_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                                                     : CHAR_TAB);
         if ($urandom_range(0, 9) > 0) pending_bytes.push_back($urandom_range(0, 1) ? CHAR_UT
                                                                                    : CHAR_LT);
         else pending_bytes.push_back(any_byte());
         pending_bytes.push_back(($urandom_range(0, 9) > 0) ? CHAR_COMMA : any_byte());
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
               0: pending_bytes.push_back(CHAR_SPACE);
               1: pending_bytes.push_back(CHAR_TAB);
               2: pending_bytes.push_back(CHAR_VT);
               default: pending_bytes.push_back(CHAR_FF);
            endcase
         end
         case ($urandom_range(0, 2))
            1: pending_bytes.push_back(CHAR_PLUS);
            2: pending_bytes.push_back(CHAR_MINUS);
            default: ;
         endcase
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
         repeat (n) pending_bytes.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 1)) begin
            pending_bytes.push_back(CHAR_DOT);
            repeat ($urandom_range(0, 4)) pending_bytes.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 9) < 3) pending_bytes.push_back(any_byte());
         if ($urandom_range(0, 9) < 2) pending_bytes.push_back(CHAR_NUL);
      end else if (kind < 80) begin
         if ($urandom_range(0, 3) == 0) pending_bytes.push_back(CHAR_SPACE);
         case ($urandom_range(0, 3))
            0: n = 1;
            1: n = 5;
            2: n = $urandom_range(2, 4);
            default: n = 6;
         endcase
         for (int i = 0; i < n; i++) begin
            b = (i < 5) ? ABORT_WORD[i] : "S";
            pending_bytes.push_back(b | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
         end
         case ($urandom_range(0, 5))
            1: pending_bytes.push_back(CHAR_SPACE);
            2: pending_bytes.push_back(CHAR_TAB);
            3: pending_bytes.push_back(CHAR_NUL);
            4: pending_bytes.push_back(any_byte());
            5: begin
               pending_bytes.push_back(CHAR_SPACE);
               pending_bytes.push_back(any_byte());
            end
            default: ;
         endcase
      end else begin
         repeat ($urandom_range(1, 8)) pending_bytes.push_back(any_byte());
      end
      if ($urandom_range(0, 4) == 0) pending_bytes.push_back(CHAR_CR);
      pending_bytes.push_back(CHAR_LF);
   endtask

   // drive request transactions from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
         gap_left    <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) n_sent <= n_sent + 1;
         if ($urandom_range(0, 49) == 0) rush <= !rush;
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            gap_left    <= (rush || hold_left > 0) ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, started once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : rx_side
      int nxt;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         nxt = stall_left;
         if (rsp_valid && !rsp_stall) nxt = quiet ? 0 : $urandom_range(0, 9);
         else if (rsp_valid && nxt > 0) nxt--;
         stall_left <= nxt;
         rsp_stall  <= (hold_left > 0) || (nxt > 0);
         if ($urandom_range(0, 39) == 0) quiet <= !quiet;
      end
   end

   always @(posedge clock) begin : monitor
      line_cmd_type want;
      if (reset) begin
         line_len = 0;
         restart_line();
      end else begin
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (rsp_command == CMD_ABORT) n_abort++;
            else n_set++;
            if (expected_commands.size() == 0) begin
               report_mismatch($sformatf("unexpected result command=%0b target=%0d",
                                         rsp_command, rsp_target_hundredths));
            end else begin
               want = expected_commands.pop_front();
               if (rsp_command !== want.command)
                  report_mismatch($sformatf("command %0b, expected %0b",
                                            rsp_command, want.command));
               if (rsp_target_hundredths !== want.target)
                  report_mismatch($sformatf("target_hundredths %0d, expected %0d",
                                            rsp_target_hundredths, want.target));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      push_text("t,-1.239\n");
      push_text("AbOrT\n");
      push_text("a\n");
      push_text("T,.\n");
      pending_bytes.push_back(CHAR_NUL);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(CHAR_LF);
      push_text("T, 7\r\n");
      while (pending_bytes.size() < 950) queue_random_line();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() > 0 || req_valid) @(posedge clock);
      while (expected_commands.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d bytes sent (%0d overlong lines), receiver held off for %0d cycles",
               n_sent, n_long, HOLD_CYCLES);
      $display("tb: %0d set-target and %0d abort results checked, %0d mismatches",
               n_set, n_abort, n_errors);
      if (n_errors == 0 && expected_commands.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
